// ----- src/timestamp_heap_merge_unit_defines.svh -----
// Assertion macros shared by the timestamp heap merge unit.
`ifndef TIMESTAMP_HEAP_MERGE_UNIT_DEFINES_SVH
`define TIMESTAMP_HEAP_MERGE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define TSHM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define TSHM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/tshm_pkg.sv -----
// Types, constants and helpers of the timestamp heap merge unit.
`default_nettype none

package tshm_pkg;

  localparam int unsigned MAX_STREAMS_DEF = 1024;
  localparam int unsigned ID_W            = 20;
  localparam int unsigned TIME_W          = 64;
  localparam int unsigned KIND_W          = 2;

  localparam logic [TIME_W-1:0] TIME_MAX   = {1'b0, {(TIME_W-1){1'b1}}};
  localparam logic [TIME_W-1:0] SIGN_BIT   = {1'b1, {(TIME_W-1){1'b0}}};
  localparam logic [TIME_W-1:0] LAST_RESET = {TIME_W{1'b1}};
  localparam logic [TIME_W-1:0] STOP_RESET = TIME_MAX;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD    = 2'd0,
    KIND_START   = 2'd1,
    KIND_ADVANCE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    RD_TOP   = 2'd0,
    RD_BUILD = 2'd1,
    RD_CHILD = 2'd2
  } rd_sel_e;

  typedef struct packed {
    logic              ended;
    logic [ID_W-1:0]   stream;
    logic [TIME_W-1:0] tstamp;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic    ld_write;
    logic    run_start;
    logic    adv_latch;
    logic    bld_dec;
    rd_sel_e rd_sel;
    logic    cur_from_bld;
    logic    cur_from_adv;
    logic    wr_cur;
    logic    wr_child;
    logic    report;
  } cmd_t;

  typedef struct packed {
    logic count_ge2;
    logic count_nz;
    logic has_child;
    logic child_wins;
    logic bld_nz;
  } sts_t;

  // Order-preserving unsigned key; an ended stream gets the largest key, tied with TIME_MAX.
  function automatic logic [TIME_W-1:0] key_of(input entry_t e);
    logic [TIME_W-1:0] k;
    k = e.ended ? {TIME_W{1'b1}} : (e.tstamp ^ SIGN_BIT);
    return k;
  endfunction

endpackage

`default_nettype wire

// ----- src/tshm_ram.sv -----
// Generic RAM: one write port, two registered read ports.
`default_nettype none

module tshm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output      logic [WIDTH-1:0]         rdata_a_o,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output      logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

// ----- src/tshm_ctrl.sv -----
// Controller state machine of the timestamp heap merge unit.
`default_nettype none

module tshm_ctrl (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [tshm_pkg::KIND_W-1:0]  kind_i,
  input  wire tshm_pkg::sts_t               sts_i,
  output      tshm_pkg::cmd_t               cmd_o,
  output      logic                         busy_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BLD_RD,
    ST_BLD_LD,
    ST_ADV_RD,
    ST_ADV_LD,
    ST_SFT_RD,
    ST_SFT_CMP,
    ST_SFT_END,
    ST_TOP_RD,
    ST_REPORT
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, busy_d;
  logic   build_q, build_d;

  always_comb begin
    cmd_o   = '0;
    cmd_o.rd_sel = tshm_pkg::RD_TOP;
    state_d = state_q;
    build_d = build_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          case (kind_i)
            tshm_pkg::KIND_LOAD: begin
              cmd_o.ld_write = 1'b1;
            end
            tshm_pkg::KIND_START: begin
              cmd_o.run_start = 1'b1;
              if (sts_i.count_ge2) begin
                build_d = 1'b1;
                state_d = ST_BLD_RD;
              end else begin
                state_d = ST_TOP_RD;
              end
            end
            tshm_pkg::KIND_ADVANCE: begin
              cmd_o.adv_latch = 1'b1;
              state_d = sts_i.count_nz ? ST_ADV_RD : ST_TOP_RD;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_BLD_RD: begin
        cmd_o.rd_sel = tshm_pkg::RD_BUILD;
        state_d = ST_BLD_LD;
      end
      ST_BLD_LD: begin
        cmd_o.cur_from_bld = 1'b1;
        state_d = ST_SFT_RD;
      end
      ST_ADV_RD: begin
        state_d = ST_ADV_LD;
      end
      ST_ADV_LD: begin
        cmd_o.cur_from_adv = 1'b1;
        state_d = ST_SFT_RD;
      end
      ST_SFT_RD: begin
        cmd_o.rd_sel = tshm_pkg::RD_CHILD;
        if (sts_i.has_child) begin
          state_d = ST_SFT_CMP;
        end else begin
          cmd_o.wr_cur = 1'b1;
          state_d = ST_SFT_END;
        end
      end
      ST_SFT_CMP: begin
        if (sts_i.child_wins) begin
          cmd_o.wr_child = 1'b1;
          state_d = ST_SFT_RD;
        end else begin
          cmd_o.wr_cur = 1'b1;
          state_d = ST_SFT_END;
        end
      end
      ST_SFT_END: begin
        // step to the next inner node while building, else fetch the top
        if (build_q && sts_i.bld_nz) begin
          cmd_o.bld_dec = 1'b1;
          state_d = ST_BLD_RD;
        end else begin
          build_d = 1'b0;
          state_d = ST_TOP_RD;
        end
      end
      ST_TOP_RD: begin
        state_d = ST_REPORT;
      end
      ST_REPORT: begin
        cmd_o.report = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    busy_d = (state_d != ST_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
      build_q <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
      build_q <= build_d;
    end
  end

  assign busy_o = busy_q;

endmodule

`default_nettype wire

// ----- src/tshm_dpath.sv -----
// Datapath: heap memory, sift registers, compare and report logic.
`default_nettype none

module tshm_dpath #(
  parameter int unsigned MAX_STREAMS = tshm_pkg::MAX_STREAMS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire tshm_pkg::cmd_t               cmd_i,
  output      tshm_pkg::sts_t               sts_o,
  input  wire logic [tshm_pkg::ID_W-1:0]    stream_id_i,
  input  wire logic [tshm_pkg::TIME_W-1:0]  next_time_i,
  input  wire logic                         ended_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [tshm_pkg::TIME_W-1:0]  cfg_wdata_i,
  output      logic [tshm_pkg::ID_W-1:0]    top_stream_o,
  output      logic [tshm_pkg::TIME_W-1:0]  top_time_o,
  output      logic                         emit_value_o,
  output      logic                         new_time_o,
  output      logic                         done_res_o,
  output      logic                         tail_mark_o,
  output      logic                         res_valid_o
);

  localparam int unsigned AW = $clog2(MAX_STREAMS);
  localparam int unsigned CW = $clog2(MAX_STREAMS + 1);
  localparam int unsigned LW = AW + 2;
  localparam int unsigned TW = tshm_pkg::TIME_W;
  localparam int unsigned IW = tshm_pkg::ID_W;
  localparam int unsigned EW = tshm_pkg::ENTRY_W;

  logic [CW-1:0]    count_q;
  logic [TW-1:0]    last_q;
  logic [TW-1:0]    stop_q;
  logic [AW-1:0]    bld_idx_q;
  logic [AW-1:0]    idx_q;
  tshm_pkg::entry_t cur_q;
  logic [TW-1:0]    adv_time_q;
  logic             adv_ended_q;

  logic [IW-1:0]    out_stream_q;
  logic [TW-1:0]    out_time_q;
  logic             out_emit_q;
  logic             out_new_q;
  logic             out_done_q;
  logic             out_tail_q;
  logic             res_valid_q;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [EW-1:0]    ram_wdata;
  logic [AW-1:0]    ram_raddr_a;
  logic [EW-1:0]    ram_rdata_a;
  logic [EW-1:0]    ram_rdata_b;

  tshm_pkg::entry_t ent_l;
  tshm_pkg::entry_t ent_r;
  tshm_pkg::entry_t child;
  tshm_pkg::entry_t ld_ent;
  logic [LW-1:0]    l_idx;
  logic [LW-1:0]    r_idx;
  logic [LW-1:0]    cnt_ext;
  logic             r_in;
  logic [TW-1:0]    key_c;
  logic [TW-1:0]    key_l;
  logic [TW-1:0]    key_r;
  logic             left_wins;
  logic             right_wins;
  logic [AW-1:0]    child_idx;
  logic             full;

  logic             heap_empty;
  logic [TW-1:0]    top_t;
  logic             top_done;
  logic             top_emit;
  logic             top_new;
  logic             top_tail;

  assign ent_l   = tshm_pkg::entry_t'(ram_rdata_a);
  assign ent_r   = tshm_pkg::entry_t'(ram_rdata_b);
  assign l_idx   = {1'b0, idx_q, 1'b1};
  assign r_idx   = l_idx + LW'(1);
  assign cnt_ext = LW'(count_q);
  assign r_in    = (r_idx < cnt_ext);
  assign full    = (count_q == CW'(MAX_STREAMS));

  // Three compares side by side; ties keep the parent, then the left child.
  assign key_c      = tshm_pkg::key_of(cur_q);
  assign key_l      = tshm_pkg::key_of(ent_l);
  assign key_r      = tshm_pkg::key_of(ent_r);
  assign left_wins  = (key_l < key_c);
  assign right_wins = r_in && (left_wins ? (key_r < key_l) : (key_r < key_c));
  assign child      = right_wins ? ent_r : ent_l;
  assign child_idx  = right_wins ? r_idx[AW-1:0] : l_idx[AW-1:0];

  assign sts_o.count_ge2  = (count_q >= CW'(2));
  assign sts_o.count_nz   = (count_q != '0);
  assign sts_o.has_child  = (l_idx < cnt_ext);
  assign sts_o.child_wins = left_wins || right_wins;
  assign sts_o.bld_nz     = (bld_idx_q != '0);

  assign ld_ent.ended  = ended_i;
  assign ld_ent.stream = stream_id_i;
  assign ld_ent.tstamp = next_time_i;

  always_comb begin
    case (cmd_i.rd_sel)
      tshm_pkg::RD_BUILD: ram_raddr_a = bld_idx_q;
      tshm_pkg::RD_CHILD: ram_raddr_a = l_idx[AW-1:0];
      default:            ram_raddr_a = '0;
    endcase
  end

  assign ram_we    = (cmd_i.ld_write && !full) || cmd_i.wr_cur || cmd_i.wr_child;
  assign ram_waddr = cmd_i.ld_write ? count_q[AW-1:0] : idx_q;
  assign ram_wdata = cmd_i.ld_write ? EW'(ld_ent) :
                     cmd_i.wr_child ? EW'(child) : EW'(cur_q);

  tshm_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_STREAMS)
  ) u_heap_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (ram_raddr_a),
    .rdata_a_o (ram_rdata_a),
    .raddr_b_i (r_idx[AW-1:0]),
    .rdata_b_o (ram_rdata_b)
  );

  // Top of heap sits on read port A during the report cycle.
  assign heap_empty = (count_q == '0);
  assign top_t      = heap_empty ? '0 : (ent_l.ended ? tshm_pkg::TIME_MAX : ent_l.tstamp);
  assign top_done   = heap_empty || ent_l.ended || ($signed(top_t) > $signed(stop_q));
  assign top_emit   = !top_done && !top_t[TW-1];
  assign top_new    = top_emit && (top_t != last_q);
  assign top_tail   = top_done && ($signed(last_q) < $signed(stop_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      last_q      <= tshm_pkg::LAST_RESET;
      stop_q      <= tshm_pkg::STOP_RESET;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.report;
      if (cfg_we_i) begin
        stop_q <= cfg_wdata_i;
      end
      if (cmd_i.ld_write && !full) begin
        count_q <= count_q + CW'(1);
      end
      if (cmd_i.run_start) begin
        last_q <= tshm_pkg::LAST_RESET;
      end else if (cmd_i.report && top_new) begin
        last_q <= top_t;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.adv_latch) begin
      adv_time_q  <= next_time_i;
      adv_ended_q <= ended_i;
    end
    if (cmd_i.run_start) begin
      bld_idx_q <= AW'((count_q >> 1) - CW'(1));
    end else if (cmd_i.bld_dec) begin
      bld_idx_q <= bld_idx_q - AW'(1);
    end
    if (cmd_i.cur_from_bld) begin
      cur_q <= ent_l;
      idx_q <= bld_idx_q;
    end else if (cmd_i.cur_from_adv) begin
      cur_q.ended  <= adv_ended_q;
      cur_q.stream <= ent_l.stream;
      cur_q.tstamp <= adv_time_q;
      idx_q        <= '0;
    end else if (cmd_i.wr_child) begin
      idx_q <= child_idx;
    end
    if (cmd_i.report) begin
      out_stream_q <= heap_empty ? '0 : ent_l.stream;
      out_time_q   <= top_t;
      out_emit_q   <= top_emit;
      out_new_q    <= top_new;
      out_done_q   <= top_done;
      out_tail_q   <= top_tail;
    end
  end

  assign top_stream_o = out_stream_q;
  assign top_time_o   = out_time_q;
  assign emit_value_o = out_emit_q;
  assign new_time_o   = out_new_q;
  assign done_res_o   = out_done_q;
  assign tail_mark_o  = out_tail_q;
  assign res_valid_o  = res_valid_q;

endmodule

`default_nettype wire

// ----- src/timestamp_heap_merge_unit.sv -----
// Top level of the timestamp heap merge unit.
`default_nettype none

// Merges time-sorted streams through a binary min-heap held in a dual-read RAM.
// A load transaction gives no result. An advance walks the
// heap from the root, one level at a time (child reads, then compare and
// write). A start runs the same sift from every inner node, the last one
// first, then reads the top and strobes the result. On an empty heap, start
// and advance go straight to reading the top. busy stays high until the
// result is registered; res_valid_o then pulses for one cycle and the
// receiver cannot stall it, so it must take every result. The user must
// write stop_time only while busy is low; the block does not enforce it.
module timestamp_heap_merge_unit #(
  parameter int unsigned MAX_STREAMS = tshm_pkg::MAX_STREAMS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output      logic                         busy,
  input  wire logic [tshm_pkg::KIND_W-1:0]  kind_i,
  input  wire logic [tshm_pkg::ID_W-1:0]    stream_id_i,
  input  wire logic [tshm_pkg::TIME_W-1:0]  next_time_i,
  input  wire logic                         ended_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [tshm_pkg::TIME_W-1:0]  cfg_wdata_i,
  output      logic                         res_valid_o,
  output      logic [tshm_pkg::ID_W-1:0]    top_stream_o,
  output      logic [tshm_pkg::TIME_W-1:0]  top_time_o,
  output      logic                         emit_value_o,
  output      logic                         new_time_o,
  output      logic                         done_res_o,
  output      logic                         tail_mark_o
);

  tshm_pkg::cmd_t cmd;
  tshm_pkg::sts_t sts;

  tshm_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .kind_i  (kind_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  tshm_dpath #(
    .MAX_STREAMS (MAX_STREAMS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .stream_id_i  (stream_id_i),
    .next_time_i  (next_time_i),
    .ended_i      (ended_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .top_stream_o (top_stream_o),
    .top_time_o   (top_time_o),
    .emit_value_o (emit_value_o),
    .new_time_o   (new_time_o),
    .done_res_o   (done_res_o),
    .tail_mark_o  (tail_mark_o),
    .res_valid_o  (res_valid_o)
  );

`include "timestamp_heap_merge_unit_defines.svh"

  `TSHM_ASSERT_IMP(a_new_needs_emit, res_valid_o && new_time_o, emit_value_o, "new time without emit")
  `TSHM_ASSERT_IMP(a_done_no_emit, res_valid_o && done_res_o, !emit_value_o, "emit after done")
  `TSHM_ASSERT_NXT(a_single_result, res_valid_o, !res_valid_o, "result strobe held twice")
  `TSHM_ASSERT_NXT(a_load_one_cycle, start && !busy && kind_i == tshm_pkg::KIND_LOAD, !busy, "load kept unit busy")

endmodule

`default_nettype wire

// ----- verif/tb_timestamp_heap_merge_unit.sv -----
// Self-checking testbench for the timestamp heap merge unit with its own heap predictor.
module tb_timestamp_heap_merge_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import tshm_pkg::*;

  localparam int unsigned HEAP_DEPTH    = MAX_STREAMS_DEF;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned RANDOM_ITEMS  = 400;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned DRAIN_LIMIT   = 50_000;
  localparam int unsigned MAX_PRINTS    = 100;
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0]   stream;
    logic [TIME_W-1:0] tstamp;
    logic              emit;
    logic              fresh;
    logic              done;
    logic              tail;
  } top_report_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [KIND_W-1:0] kind_i;
  logic [ID_W-1:0]   stream_id_i;
  logic [TIME_W-1:0] next_time_i;
  logic              ended_i;
  logic              cfg_we_i;
  logic [TIME_W-1:0] cfg_wdata_i;
  logic              res_valid_o;
  logic [ID_W-1:0]   top_stream_o;
  logic [TIME_W-1:0] top_time_o;
  logic              emit_value_o;
  logic              new_time_o;
  logic              done_res_o;
  logic              tail_mark_o;

  timestamp_heap_merge_unit dut (
    .clk_i, .rst_ni, .start, .busy, .kind_i, .stream_id_i, .next_time_i, .ended_i,
    .cfg_we_i, .cfg_wdata_i, .res_valid_o, .top_stream_o, .top_time_o, .emit_value_o,
    .new_time_o, .done_res_o, .tail_mark_o
  );

  // Predicted heap contents and run state.
  logic [TIME_W-1:0] hp_time   [HEAP_DEPTH];
  logic [ID_W-1:0]   hp_stream [HEAP_DEPTH];
  logic              hp_ended  [HEAP_DEPTH];
  int unsigned       hp_count;
  logic [TIME_W-1:0] last_emitted;
  logic [TIME_W-1:0] stop_limit;

  top_report_t pending_tops[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [TIME_W-1:0] got,
                                 input logic [TIME_W-1:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS)
      $display("%0t mismatch %s: got %h, want %h", $realtime, what, got, want);
  endtask

  always @(posedge clk_i) begin : result_check
    top_report_t want;
    if (rst_ni && res_valid_o) begin
      if (pending_tops.size() == 0) begin
        report_mismatch("result with none pending", top_time_o, '0);
      end else begin
        want = pending_tops.pop_front();
        if (top_stream_o !== want.stream)
          report_mismatch("top_stream", TIME_W'(top_stream_o), TIME_W'(want.stream));
        if (top_time_o !== want.tstamp) report_mismatch("top_time", top_time_o, want.tstamp);
        if (emit_value_o !== want.emit)
          report_mismatch("emit_value", TIME_W'(emit_value_o), TIME_W'(want.emit));
        if (new_time_o !== want.fresh)
          report_mismatch("new_time", TIME_W'(new_time_o), TIME_W'(want.fresh));
        if (done_res_o !== want.done)
          report_mismatch("done_res", TIME_W'(done_res_o), TIME_W'(want.done));
        if (tail_mark_o !== want.tail)
          report_mismatch("tail_mark", TIME_W'(tail_mark_o), TIME_W'(want.tail));
      end
    end
  end

  // Ended streams sort no earlier than any time; they tie with TIME_MAX.
  function automatic logic [TIME_W-1:0] sort_key(int unsigned i);
    return hp_ended[i] ? '1 : (hp_time[i] ^ SIGN_BIT);
  endfunction

  function automatic void sift_heap(int unsigned i);
    int unsigned       l;
    int unsigned       best;
    logic [TIME_W-1:0] t;
    logic [ID_W-1:0]   s;
    logic              e;
    while (1) begin
      l = 2 * i + 1;
      best = i;
      // Move only on a strictly earlier child; ties keep the parent, then the left child.
      if (l < hp_count && sort_key(l) < sort_key(best)) best = l;
      if (l + 1 < hp_count && sort_key(l + 1) < sort_key(best)) best = l + 1;
      if (best == i) break;
      t = hp_time[i];
      s = hp_stream[i];
      e = hp_ended[i];
      hp_time[i] = hp_time[best];
      hp_stream[i] = hp_stream[best];
      hp_ended[i] = hp_ended[best];
      hp_time[best] = t;
      hp_stream[best] = s;
      hp_ended[best] = e;
      i = best;
    end
  endfunction

  function automatic top_report_t read_top();
    top_report_t r;
    r = '0;
    if (hp_count == 0) begin
      r.done = 1'b1;
    end else begin
      r.stream = hp_stream[0];
      r.tstamp = hp_ended[0] ? TIME_MAX : hp_time[0];
      r.done = hp_ended[0] || ($signed(r.tstamp) > $signed(stop_limit));
    end
    if (r.done) begin
      r.tail = $signed(last_emitted) < $signed(stop_limit);
    end else if (!r.tstamp[TIME_W-1]) begin
      r.emit = 1'b1;
      if (r.tstamp != last_emitted) begin
        r.fresh = 1'b1;
        last_emitted = r.tstamp;
      end
    end
    return r;
  endfunction

  // Apply one accepted transaction; return 1 when it yields a top report.
  function automatic bit merge_step(input logic [KIND_W-1:0] k, input logic [ID_W-1:0] id,
                                    input logic [TIME_W-1:0] t, input logic e,
                                    output top_report_t r);
    int unsigned i;
    bit          yields;
    r = '0;
    yields = 1'b0;
    case (k)
      KIND_LOAD: begin
        if (hp_count < HEAP_DEPTH) begin
          hp_stream[hp_count] = id;
          hp_time[hp_count] = t;
          hp_ended[hp_count] = e;
          hp_count++;
        end
      end
      KIND_START: begin
        last_emitted = LAST_RESET;
        if (hp_count >= 2)
          for (i = hp_count / 2 - 1; i > 0; i--) sift_heap(i);
        if (hp_count > 0) sift_heap(0);
        r = read_top();
        yields = 1'b1;
      end
      KIND_ADVANCE: begin
        if (hp_count > 0) begin
          hp_time[0] = t;
          hp_ended[0] = e;
          sift_heap(0);
        end
        r = read_top();
        yields = 1'b1;
      end
      default: ;
    endcase
    return yields;
  endfunction

  task automatic send_item(input logic [KIND_W-1:0] k, input logic [ID_W-1:0] id,
                           input logic [TIME_W-1:0] t, input logic e);
    top_report_t r;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      start <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
    end
    burst_left--;
    start <= 1'b1;
    kind_i <= k;
    stream_id_i <= id;
    next_time_i <= t;
    ended_i <= e;
    do @(posedge clk_i); while (busy);
    if (merge_step(k, id, t, e, r)) pending_tops.push_back(r);
  endtask

  // Hold off until every pending report is in and the block is idle.
  task automatic drain_results();
    start <= 1'b0;
    burst_left = 0;
    while (pending_tops.size() != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_stop_time(input logic [TIME_W-1:0] v);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    stop_limit = v;
  endtask

  function automatic logic [TIME_W-1:0] random_stamp();
    case ($urandom_range(0, 7))
      0: return {$urandom, $urandom};
      1: return '0 - 64'($urandom_range(1, 1000));
      default: return 64'($urandom_range(0, 2000));
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] random_stop();
    case ($urandom_range(0, 5))
      0: return TIME_MAX;
      1: return SIGN_BIT;
      2: return '0;
      3: return LAST_RESET;
      4: return {$urandom, $urandom};
      default: return 64'($urandom_range(0, 3000));
    endcase
  endfunction

  // Mostly a time at or after the top stream's, sometimes its end or noise.
  function automatic void pick_successor(output logic [TIME_W-1:0] t, output logic e);
    logic [TIME_W-1:0] base;
    base = (hp_count == 0 || hp_ended[0]) ? '0 : hp_time[0];
    e = ($urandom_range(0, 9) == 0);
    case ($urandom_range(0, 9))
      0: t = {$urandom, $urandom};
      1: t = base - 64'($urandom_range(1, 100));
      default: t = base + 64'($urandom_range(0, 20));
    endcase
  endfunction

  task automatic test_empty_heap();
    send_item(KIND_START, '0, '0, 1'b0);
    send_item(KIND_ADVANCE, '1, TIME_MAX, 1'b1);
    send_item(KIND_SPARE, '1, '1, 1'b1);
    write_stop_time(SIGN_BIT);
    send_item(KIND_ADVANCE, '0, SIGN_BIT, 1'b0);
    write_stop_time(TIME_MAX);
  endtask

  task automatic test_directed_merge();
    send_item(KIND_LOAD, 20'h00000, SIGN_BIT, 1'b0);
    send_item(KIND_LOAD, 20'hFFFFF, TIME_MAX, 1'b0);
    send_item(KIND_LOAD, 20'h5A5A5, 64'd5, 1'b0);
    send_item(KIND_LOAD, 20'hA5A5A, 64'd5, 1'b0);
    send_item(KIND_LOAD, 20'h12345, 64'd3, 1'b1);
    send_item(KIND_LOAD, 20'h00001, LAST_RESET, 1'b0);
    send_item(KIND_START, '0, '0, 1'b0);
    send_item(KIND_ADVANCE, '0, LAST_RESET, 1'b0);
    send_item(KIND_ADVANCE, '0, 64'd5, 1'b0);
    send_item(KIND_ADVANCE, '0, 64'd5, 1'b0);
    send_item(KIND_ADVANCE, '0, 64'd6, 1'b0);
    send_item(KIND_ADVANCE, '0, TIME_MAX, 1'b0);
    // Append without a rebuild; the top stays where it is until the next start.
    send_item(KIND_LOAD, 20'h33333, 64'd1, 1'b0);
    send_item(KIND_ADVANCE, '0, 64'd2, 1'b0);
    send_item(KIND_ADVANCE, '0, '0, 1'b1);
    send_item(KIND_ADVANCE, '0, '0, 1'b1);
    write_stop_time(64'd6);
    send_item(KIND_ADVANCE, '0, 64'd9, 1'b0);
    send_item(KIND_ADVANCE, '0, 64'd4, 1'b0);
  endtask

  task automatic test_random_merge();
    int unsigned       sent;
    int unsigned       n;
    logic [TIME_W-1:0] t;
    logic              e;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) write_stop_time(random_stop());
      else if ($urandom_range(0, 4) == 0) drain_results();
      n = $urandom_range(1, 8);
      repeat (n) begin
        send_item(KIND_LOAD, 20'($urandom), random_stamp(), $urandom_range(0, 15) == 0);
        sent++;
      end
      send_item(KIND_START, 20'($urandom), {$urandom, $urandom}, 1'($urandom));
      sent++;
      n = $urandom_range(5, 40);
      repeat (n) begin
        case ($urandom_range(0, 19))
          0: begin
            send_item(KIND_LOAD, 20'($urandom), random_stamp(), 1'($urandom));
            sent++;
          end
          1: send_item(KIND_SPARE, 20'($urandom), {$urandom, $urandom}, 1'($urandom));
          default: begin
            pick_successor(t, e);
            send_item(KIND_ADVANCE, 20'($urandom), t, e);
            sent++;
          end
        endcase
      end
    end
  endtask

  task automatic test_heap_full();
    logic [TIME_W-1:0] t;
    logic              e;
    write_stop_time(TIME_MAX);
    // Fill to capacity, then push a few more that must be dropped.
    while (hp_count < HEAP_DEPTH)
      send_item(KIND_LOAD, 20'($urandom), random_stamp(), $urandom_range(0, 31) == 0);
    repeat (3) send_item(KIND_LOAD, 20'($urandom), SIGN_BIT, 1'b0);
    send_item(KIND_START, '0, '0, 1'b0);
    repeat (20) begin
      pick_successor(t, e);
      send_item(KIND_ADVANCE, '0, t, e);
    end
  endtask

  initial begin
    int unsigned waited;
    rst_ni = 1'b0;
    start = 1'b0;
    kind_i = KIND_LOAD;
    stream_id_i = '0;
    next_time_i = '0;
    ended_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    hp_count = 0;
    last_emitted = LAST_RESET;
    stop_limit = STOP_RESET;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_heap();
    test_directed_merge();
    test_random_merge();
    test_heap_full();

    start <= 1'b0;
    waited = 0;
    while (pending_tops.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_tops.size() != 0)
      report_mismatch("reports never received", 64'(pending_tops.size()), '0);

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/tshm_pkg.sv
src/tshm_ram.sv
src/tshm_ctrl.sv
src/tshm_dpath.sv
src/timestamp_heap_merge_unit.sv
verif/tb_timestamp_heap_merge_unit.sv
